[design/efc_pkg.sv]
// Package for the event queue with per-event counters.
// Holds the word types, operation codes and default sizes; no dependencies.
`default_nettype none

package efc_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int NUM_EVENTS_DEF = 16;

  localparam int CODE_W = 4;
  localparam int AUX_W  = 32;
  localparam int STAT_W = 8;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [CODE_W-1:0] VOID_CODE = '0;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CODE_W-1:0] event_code;
    logic [AUX_W-1:0]  aux_word;
  } in_item_t;

  typedef struct packed {
    logic              item_valid;
    logic [CODE_W-1:0] popped_event;
    logic [AUX_W-1:0]  popped_aux;
    logic [STAT_W-1:0] statistic;
    logic              overflow_seen;
  } out_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [AUX_W-1:0]  aux;
  } entry_t;

  // Request from the queue control to the statistics block.
  typedef struct packed {
    logic              push;
    logic              query;
    logic [CODE_W-1:0] code;
  } stats_req_t;

endpackage

`default_nettype wire

[design/efc_entry_ram.sv]
// Entry storage of the event queue: one write port, one registered read port.
// Depends on efc_pkg for the entry type.
`default_nettype none

module efc_entry_ram #(
  parameter int DEPTH = efc_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire efc_pkg::entry_t          wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output efc_pkg::entry_t               rdata
);

  efc_pkg::entry_t mem [DEPTH];
  efc_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[design/efc_stats.sv]
// Per-event 8-bit counters and their running total, with the query read path.
// Depends on efc_pkg for the request type and widths.
`default_nettype none

module efc_stats #(
  parameter int NUM_EVENTS = efc_pkg::NUM_EVENTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire efc_pkg::stats_req_t            req,
  output logic [efc_pkg::STAT_W-1:0]          stat
);

  localparam int          IDX_W    = $clog2(NUM_EVENTS);
  localparam logic [31:0] NUM_EV_U = 32'(NUM_EVENTS);

  logic [efc_pkg::STAT_W-1:0] cnt_r [NUM_EVENTS];
  logic [efc_pkg::STAT_W-1:0] total_r;
  logic [IDX_W-1:0]           idx;
  logic                       in_range;

  assign idx      = IDX_W'(req.code);
  assign in_range = 32'(req.code) < NUM_EV_U;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_EVENTS; i++) begin
        cnt_r[i] <= '0;
      end
      total_r <= '0;
    end else if (req.push && in_range) begin
      cnt_r[idx] <= cnt_r[idx] + 1'b1;
      total_r    <= total_r + 1'b1;
    end
  end

  // The void code reads the running total; codes without a counter read zero.
  always_comb begin
    stat = '0;
    if (req.query) begin
      if (req.code == efc_pkg::VOID_CODE) begin
        stat = total_r;
      end else if (in_range) begin
        stat = cnt_r[idx];
      end
    end
  end

endmodule

`default_nettype wire

[design/event_fifo_with_counters.sv]
// Top level of the event queue with per-event counters.
// Depends on efc_pkg, efc_entry_ram and efc_stats.
// Every word (push, pop, statistics query or unused operation) yields exactly one result
// word. A word is taken into an input register, does its pointer, occupancy and counter
// update there, and moves into the result register; a new word can be accepted every
// cycle while the output side does not stall. The result is presented from the result
// register. The single read port of the entry memory is read once per word, and its
// registered data forms the popped fields of the result. No clearing pass is needed after
// reset.
`default_nettype none

module event_fifo_with_counters #(
  parameter int DEPTH      = efc_pkg::DEPTH_DEF,
  parameter int NUM_EVENTS = efc_pkg::NUM_EVENTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire efc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output efc_pkg::out_item_t      out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  logic                       in_v_r;
  efc_pkg::in_item_t          in_item_r;
  logic                       out_v_r;
  logic                       out_pop_r;
  logic [efc_pkg::STAT_W-1:0] out_stat_r;
  logic                       out_ovf_r;

  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             ovf_r, ovf_nxt;

  logic out_adv, fire, is_push, is_pop, is_query, full, empty, do_push, do_pop;

  efc_pkg::entry_t            wdata, rdata;
  efc_pkg::stats_req_t        stats_req;
  logic [efc_pkg::STAT_W-1:0] stat;

  assign out_adv  = !out_v_r || !out_stall;
  assign in_stall = in_v_r && !out_adv;
  assign fire     = in_v_r && out_adv;

  assign is_push  = fire && (in_item_r.operation == efc_pkg::OP_PUSH);
  assign is_pop   = fire && (in_item_r.operation == efc_pkg::OP_POP);
  assign is_query = fire && (in_item_r.operation == efc_pkg::OP_QUERY);

  assign full    = occ_r == OCC_FULL;
  assign empty   = occ_r == '0;
  assign do_push = is_push && !full;
  assign do_pop  = is_pop && !empty;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    occ_nxt    = occ_r;
    ovf_nxt    = ovf_r | (is_push && full);
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      occ_nxt    = occ_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      occ_nxt    = occ_r - 1'b1;
    end
  end

  // Input stage: takes a new word whenever the stage is empty or empties in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      occ_r    <= '0;
      ovf_r    <= 1'b0;
    end else begin
      if (out_adv) begin
        out_v_r <= in_v_r;
      end
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      occ_r    <= occ_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pop_r  <= do_pop;
      out_stat_r <= stat;
      out_ovf_r  <= ovf_nxt;
    end
  end

  assign wdata.code = in_item_r.event_code;
  assign wdata.aux  = in_item_r.aux_word;

  // The read data register loads together with the result register, so it
  // holds the popped entry for as long as the result waits.
  efc_entry_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (wr_ptr_r),
    .wdata (wdata),
    .re    (fire),
    .raddr (rd_ptr_r),
    .rdata (rdata)
  );

  assign stats_req.push  = do_push;
  assign stats_req.query = is_query;
  assign stats_req.code  = in_item_r.event_code;

  efc_stats #(
    .NUM_EVENTS (NUM_EVENTS)
  ) u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (stats_req),
    .stat  (stat)
  );

  assign out_valid              = out_v_r;
  assign out_data.item_valid    = out_pop_r;
  assign out_data.popped_event  = out_pop_r ? rdata.code : '0;
  assign out_data.popped_aux    = out_pop_r ? rdata.aux : '0;
  assign out_data.statistic     = out_stat_r;
  assign out_data.overflow_seen = out_ovf_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_FULL)
    else $error("queue occupancy exceeds its depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("empty queue with mismatched pointers");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared without reset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (occ_r == $past(occ_r) - 1'b1))
    else $error("pop did not reduce occupancy by one");

endmodule

`default_nettype wire

[tb/sv/tb_event_fifo_with_counters.sv]
`timescale 1ns / 1ps
// Testbench for event_fifo_with_counters: push, pop, query and unused words with random
// gaps, output stalls and long hold-offs, each result word checked against a predictor.
// Depends on efc_pkg and the design files of event_fifo_with_counters.

module tb_event_fifo_with_counters;
  import efc_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int NUM_EVENTS     = NUM_EVENTS_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS   = 1200;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RUN_LIMIT_NS   = 5_000_000;

  typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED, BURST_NOISE} burst_t;

  class event_queue_scoreboard;
    entry_t            entries[DEPTH];
    int                rd_ptr;
    int                wr_ptr;
    int                fill;
    logic [STAT_W-1:0] ev_count[NUM_EVENTS];
    logic [STAT_W-1:0] total;
    logic              overflow;
    out_item_t         expected[$];
    int                errors;

    function new();
      rd_ptr   = 0;
      wr_ptr   = 0;
      fill     = 0;
      total    = '0;
      overflow = 1'b0;
      errors   = 0;
      foreach (ev_count[i]) ev_count[i] = '0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // Applies one accepted word to the queue state and stores the result it must produce.
    function void note_word(in_item_t w);
      out_item_t r;
      r = '0;
      case (w.operation)
        OP_PUSH: begin
          if (fill < DEPTH) begin
            entries[wr_ptr].code = w.event_code;
            entries[wr_ptr].aux  = w.aux_word;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            fill++;
            if (int'(w.event_code) < NUM_EVENTS) begin
              ev_count[w.event_code] = ev_count[w.event_code] + 1'b1;
              total = total + 1'b1;
            end
          end else begin
            overflow = 1'b1;
          end
        end
        OP_POP: begin
          if (fill > 0) begin
            r.item_valid   = 1'b1;
            r.popped_event = entries[rd_ptr].code;
            r.popped_aux   = entries[rd_ptr].aux;
            rd_ptr = (rd_ptr + 1) % DEPTH;
            fill--;
          end
        end
        OP_QUERY: begin
          if (w.event_code == VOID_CODE) r.statistic = total;
          else if (int'(w.event_code) < NUM_EVENTS) r.statistic = ev_count[w.event_code];
        end
        default: ;
      endcase
      r.overflow_seen = overflow;
      expected.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected.size() == 0) begin
        report($sformatf("result word with nothing expected: %h", got));
      end else begin
        want = expected.pop_front();
        if (got.item_valid !== want.item_valid)
          report($sformatf("item_valid expected %0h, got %0h", want.item_valid, got.item_valid));
        if (got.popped_event !== want.popped_event)
          report($sformatf("popped_event expected %0h, got %0h",
                           want.popped_event, got.popped_event));
        if (got.popped_aux !== want.popped_aux)
          report($sformatf("popped_aux expected %h, got %h", want.popped_aux, got.popped_aux));
        if (got.statistic !== want.statistic)
          report($sformatf("statistic expected %0d, got %0d", want.statistic, got.statistic));
        if (got.overflow_seen !== want.overflow_seen)
          report($sformatf("overflow_seen expected %0h, got %0h",
                           want.overflow_seen, got.overflow_seen));
      end
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      hold_off  = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  event_queue_scoreboard sb = new();

  event_fifo_with_counters DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap(bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t make_word(logic [1:0] op, logic [CODE_W-1:0] code,
                                         logic [AUX_W-1:0] aux);
    in_item_t w;
    w.operation  = op;
    w.event_code = code;
    w.aux_word   = aux;
    return w;
  endfunction

  // Most codes hit one hot event so that its counter wraps during the run.
  function automatic in_item_t random_word(burst_t mode, logic [CODE_W-1:0] hot);
    in_item_t w;
    int roll;
    int aux_roll;
    roll     = $urandom_range(99);
    aux_roll = $urandom_range(99);
    w.event_code = ($urandom_range(99) < 55) ? hot : CODE_W'($urandom());
    if (aux_roll < 5) w.aux_word = '0;
    else if (aux_roll < 10) w.aux_word = '1;
    else w.aux_word = $urandom();
    case (mode)
      BURST_FILL:  w.operation = (roll < 85) ? OP_PUSH : ((roll < 95) ? OP_QUERY : OP_POP);
      BURST_DRAIN: w.operation = (roll < 80) ? OP_POP : ((roll < 90) ? OP_PUSH : OP_QUERY);
      BURST_MIXED: begin
        if (roll < 45) w.operation = OP_PUSH;
        else if (roll < 85) w.operation = OP_POP;
        else if (roll < 96) w.operation = OP_QUERY;
        else w.operation = OP_UNUSED;
      end
      default: begin
        if (roll < 40) w.operation = OP_QUERY;
        else if (roll < 70) w.operation = OP_UNUSED;
        else if (roll < 85) w.operation = OP_PUSH;
        else w.operation = OP_POP;
      end
    endcase
    return w;
  endfunction

  // Offers one word until it is taken, then idles the input for the gap that it is given.
  task automatic send_word(in_item_t w, int gap);
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(w);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    send_word(make_word(OP_POP, 4'd3, 32'h0000_0000), 0);
    send_word(make_word(OP_QUERY, VOID_CODE, 32'h0000_0000), 0);
    send_word(make_word(OP_PUSH, 4'd1, 32'h0000_0000), 0);
    send_word(make_word(OP_PUSH, 4'hF, 32'hFFFF_FFFF), 1);
    send_word(make_word(OP_PUSH, VOID_CODE, 32'hAAAA_AAAA), 0);
    send_word(make_word(OP_PUSH, 4'd7, 32'h5555_5555), 2);
    send_word(make_word(OP_PUSH, 4'hF, 32'h1234_5678), 0);
    send_word(make_word(OP_QUERY, 4'd1, 32'hFFFF_FFFF), 0);
    send_word(make_word(OP_QUERY, 4'hF, 32'h0000_0000), 0);
    send_word(make_word(OP_QUERY, VOID_CODE, 32'h0000_0000), 0);
    send_word(make_word(OP_QUERY, 4'd7, 32'h0000_0000), 1);
    send_word(make_word(OP_QUERY, 4'd4, 32'h0000_0000), 0);
    send_word(make_word(OP_UNUSED, 4'hF, 32'hFFFF_FFFF), 0);
    send_word(make_word(OP_UNUSED, VOID_CODE, 32'h0000_0000), 0);
    repeat (5) send_word(make_word(OP_POP, 4'hF, 32'hFFFF_FFFF), 0);
    send_word(make_word(OP_POP, VOID_CODE, 32'h0000_0000), 3);
    send_word(make_word(OP_QUERY, VOID_CODE, 32'h0000_0000), 0);
  endtask

  task automatic run_random();
    int sent;
    int seg_len;
    bit quiet;
    burst_t mode;
    logic [CODE_W-1:0] hot;
    sent = 0;
    hot  = CODE_W'($urandom());
    // A long push burst first, so that the queue fills and a push overflows early on.
    mode = BURST_FILL;
    seg_len = 50;
    while (sent < RANDOM_WORDS) begin
      quiet = ($urandom_range(3) == 0);
      for (int i = 0; i < seg_len; i++) begin
        send_word(random_word(mode, hot), pick_gap(quiet));
        sent++;
      end
      mode    = burst_t'($urandom_range(3));
      seg_len = $urandom_range(10, 60);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: checks accepted words and stalls at random, with quiet windows.
  initial begin : result_side
    int stall_left;
    int window;
    bit quiet;
    stall_left = 0;
    window     = 0;
    quiet      = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_result(out_data);
      if (window == 0) begin
        window = $urandom_range(50, 200);
        quiet  = ($urandom_range(3) == 0);
      end
      window--;
      if (stall_left > 0) begin
        stall_left--;
      end else if (!quiet && $urandom_range(99) < 25) begin
        stall_left = ($urandom_range(99) < 88) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      out_stall <= hold_off || (stall_left > 0);
    end
  end

  // Long hold-offs of the receiver while the sender keeps offering words.
  initial begin : pressure
    @(posedge rst_n);
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
    repeat (2500) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : run_limit
    #RUN_LIMIT_NS;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
